// ===== design/bgpd_pkg.sv =====
// ----------------------------------------------------------------------------
// bgpd_pkg
// Shared widths, discharge curve, register indexes and control types for the
// battery gauge and power detect block.
// ----------------------------------------------------------------------------
`default_nettype none

package bgpd_pkg;

   localparam int HISTORY_DEPTH_DEF = 4;

   localparam int MV_W        = 13;
   localparam int PCT_W       = 8;
   localparam int MIN_W       = 23;
   localparam int TICK_W      = 32;
   localparam int TPM_W       = 16;
   localparam int CNT8_W      = 8;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 3;

   // discharge curve, highest voltage first
   localparam int CURVE_POINTS = 13;
   localparam int CURVE_IDX_W  = $clog2(CURVE_POINTS);
   localparam int PC_W         = 7;

   localparam logic [MV_W-1:0] CURVE_MV [CURVE_POINTS] = '{
      13'd4200, 13'd4060, 13'd3950, 13'd3870, 13'd3800, 13'd3740, 13'd3690,
      13'd3640, 13'd3580, 13'd3480, 13'd3380, 13'd3200, 13'd2900
   };
   localparam logic [PC_W-1:0] CURVE_PC [CURVE_POINTS] = '{
      7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50, 7'd40,
      7'd30, 7'd20, 7'd10, 7'd5, 7'd2, 7'd0
   };

   // segment quotient never exceeds the segment's percent span
   localparam int PCT_QW = 7;
   localparam int NUM_W  = MV_W + PCT_QW;

   localparam logic [MV_W-1:0]   STEP_THRESHOLD_RST   = 13'd250;
   localparam logic [MV_W-1:0]   EXTERNAL_CERTAIN_RST = 13'd4300;
   localparam logic [MV_W-1:0]   CELL_MAX_RST         = 13'd4200;
   localparam logic [CNT8_W-1:0] TICKS_PER_PUSH_RST   = 8'd10;
   localparam logic [CNT8_W-1:0] SETTLE_TICKS_RST     = 8'd50;
   localparam logic [TPM_W-1:0]  TICKS_PER_MINUTE_RST = 16'd600;
   localparam logic signed [PCT_W-1:0] PCT_UNKNOWN    = -8'sd1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_STEP_THRESHOLD   = 3'd0,
      CSR_EXTERNAL_CERTAIN = 3'd1,
      CSR_CELL_MAX         = 3'd2,
      CSR_TICKS_PER_PUSH   = 3'd3,
      CSR_SETTLE_TICKS     = 3'd4,
      CSR_TICKS_PER_MINUTE = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [MV_W-1:0] sample_mv;
   } req_type;

   typedef struct packed {
      logic                    on_external;
      logic signed [PCT_W-1:0] charge_percent;
      logic [MIN_W-1:0]        minutes_external;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DECIDE,
      ST_SEARCH,
      ST_DIVIDE,
      ST_WAIT,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic load;
      logic read;
      logic decide;
      logic search;
      logic divide;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic search_needed;
      logic seg_found;
      logic div_done;
      logic min_busy;
      logic rsp_free;
   } status_type;

endpackage

`default_nettype wire

// ===== design/bgpd_stream_if.sv =====
// ----------------------------------------------------------------------------
// bgpd_stream_if
// Valid/ready channel carrying one request or result payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface bgpd_stream_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

// ===== design/bgpd_ram.sv =====
// ----------------------------------------------------------------------------
// bgpd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bgpd_ram #(
   parameter int WIDTH  = 13,
   parameter int DEPTH  = 4,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/bgpd_ctrl.sv =====
// ----------------------------------------------------------------------------
// bgpd_ctrl
// Sequencer: accepts a request, steps the datapath through history read,
// mode decision, curve search and divide when a search is needed, waits for the
// minutes divider and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bgpd_ctrl import bgpd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = status.search_needed ? ST_SEARCH : ST_WAIT;
         end
         ST_SEARCH: begin
            cmd.search = 1'b1;
            if (status.seg_found) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.divide = 1'b1;
            if (status.div_done) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (!status.min_busy) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (status.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== design/bgpd_dp.sv =====
// ----------------------------------------------------------------------------
// bgpd_dp
// Datapath: config registers, history ring, mode and settle logic, curve
// segment search with a bit-serial divider, minutes divider, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bgpd_dp import bgpd_pkg::*; #(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output status_type             status,
   input  logic [MV_W-1:0]        req_sample_mv,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_payload
);

   localparam int PTR_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
   localparam int DCNT_W = $clog2(PCT_QW);
   localparam int MCNT_W = $clog2(TICK_W);
   localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(HISTORY_DEPTH - 1);
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(HISTORY_DEPTH);
   localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(PCT_QW - 1);
   localparam logic [MCNT_W-1:0] MCNT_LAST = MCNT_W'(TICK_W - 1);

   // config
   logic [MV_W-1:0]   thr_ff, thr_in;
   logic [MV_W-1:0]   ext_cert_ff, ext_cert_in;
   logic [MV_W-1:0]   cell_max_ff, cell_max_in;
   logic [CNT8_W-1:0] tpp_ff, tpp_in;
   logic [CNT8_W-1:0] settle_ticks_ff, settle_ticks_in;
   logic [TPM_W-1:0]  tpm_ff, tpm_in;

   // gauge state
   logic                    primed_ff, primed_in;
   logic                    ext_mode_ff, ext_mode_in;
   logic signed [PCT_W-1:0] last_pct_ff, last_pct_in;
   logic [TICK_W-1:0]       ext_ticks_ff, ext_ticks_in;
   logic [CNT8_W-1:0]       settle_ff, settle_in;
   logic [PTR_W-1:0]        ptr_ff, ptr_in;
   logic [CNT8_W-1:0]       push_ff, push_in;
   logic [FILL_W-1:0]       fill_ff, fill_in;
   logic [MV_W-1:0]         prime_val_ff, prime_val_in;
   logic [MV_W-1:0]         mv_ff, mv_in;

   // curve unit
   logic [MV_W-1:0]        cv_ff, cv_in;
   logic [CURVE_IDX_W-1:0] idx_ff, idx_in;
   logic [MV_W-1:0]        rem_ff, rem_in;
   logic [PCT_QW-1:0]      qlow_ff, qlow_in;
   logic [MV_W-1:0]        den_ff, den_in;
   logic [PC_W-1:0]        base_ff, base_in;
   logic                   zspan_ff, zspan_in;
   logic [DCNT_W-1:0]      dcnt_ff, dcnt_in;

   // minutes divider
   logic [TICK_W-1:0] mdvd_ff, mdvd_in;
   logic [TPM_W-1:0]  mrem_ff, mrem_in;
   logic [TPM_W-1:0]  mdiv_ff, mdiv_in;
   logic [MCNT_W-1:0] mcnt_ff, mcnt_in;
   logic              mbusy_ff, mbusy_in;

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // combinational
   logic [MV_W-1:0]        ram_rdata;
   logic                   ram_we;
   logic                   ram_hit;
   logic [MV_W-1:0]        oldest;
   logic                   mode_cur, rose, fell, plug, unplug, mode_new;
   logic [CNT8_W-1:0]      settle_mid;
   logic                   need_curve;
   logic [MV_W-1:0]        target;
   logic                   end_hi, end_lo;
   logic [TICK_W-1:0]      ticks_new;
   logic [CNT8_W-1:0]      push_next;
   logic                   push_now;
   logic [CURVE_IDX_W-1:0] idx_prev;
   logic [MV_W-1:0]        seg_mv, span_mv, seg_off;
   logic [PC_W-1:0]        span_pc;
   logic                   found;
   logic [NUM_W-1:0]       num;
   logic [MV_W:0]          dshift, ddiff;
   logic                   qbit;
   logic [PCT_QW-1:0]      quot;
   logic [TPM_W:0]         mshift, mdiff;
   logic                   mq;
   logic [MIN_W-1:0]       minutes_sat;

   bgpd_ram #(
      .WIDTH  (MV_W),
      .DEPTH  (HISTORY_DEPTH),
      .ADDR_W (PTR_W)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ptr_ff),
      .wr_data (mv_ff),
      .rd_en   (cmd.read),
      .rd_addr (ptr_ff),
      .rd_data (ram_rdata)
   );

   // mode decision
   always_comb begin
      ram_hit  = FILL_W'(ptr_ff) < fill_ff;
      oldest   = !primed_ff ? mv_ff : (ram_hit ? ram_rdata : prime_val_ff);
      mode_cur = !primed_ff ? (mv_ff > ext_cert_ff) : ext_mode_ff;
      rose     = (mv_ff > oldest) && ((mv_ff - oldest) > thr_ff);
      fell     = (oldest > mv_ff) && ((oldest - mv_ff) > thr_ff);
      plug     = !mode_cur && ((mv_ff > ext_cert_ff) || rose);
      unplug   = mode_cur && fell && (mv_ff <= cell_max_ff);
      mode_new = plug ? 1'b1 : (unplug ? 1'b0 : mode_cur);
      settle_mid = unplug ? settle_ticks_ff : settle_ff;
      need_curve = 1'b0;
      target     = mv_ff;
      if (plug) begin
         need_curve = (oldest <= cell_max_ff);
         target     = oldest;
      end else if (!mode_new && (settle_mid == '0)) begin
         need_curve = 1'b1;
      end
      end_hi = target >= CURVE_MV[0];
      end_lo = target <= CURVE_MV[CURVE_POINTS-1];
      if (!mode_new) begin
         ticks_new = '0;
      end else if (plug) begin
         ticks_new = TICK_W'(1);
      end else if (ext_ticks_ff == '1) begin
         ticks_new = ext_ticks_ff;
      end else begin
         ticks_new = ext_ticks_ff + TICK_W'(1);
      end
      push_next = push_ff + CNT8_W'(1);
      push_now  = push_next >= tpp_ff;
      ram_we    = cmd.decide && push_now;
   end

   // curve segment and divider steps (percent and minutes)
   always_comb begin
      idx_prev = idx_ff - CURVE_IDX_W'(1);
      seg_mv   = CURVE_MV[idx_ff];
      found    = cv_ff >= seg_mv;
      span_mv  = CURVE_MV[idx_prev] - seg_mv;
      span_pc  = CURVE_PC[idx_prev] - CURVE_PC[idx_ff];
      seg_off  = cv_ff - seg_mv;
      num      = NUM_W'(seg_off) * NUM_W'(span_pc) + NUM_W'(span_mv >> 1);
      dshift   = {rem_ff, qlow_ff[PCT_QW-1]};
      ddiff    = dshift - {1'b0, den_ff};
      qbit     = dshift >= {1'b0, den_ff};
      quot     = {qlow_ff[PCT_QW-2:0], qbit};
      mshift   = {mrem_ff, mdvd_ff[TICK_W-1]};
      mdiff    = mshift - {1'b0, mdiv_ff};
      mq       = mshift >= {1'b0, mdiv_ff};
      minutes_sat = (|mdvd_ff[TICK_W-1:MIN_W]) ? '1 : mdvd_ff[MIN_W-1:0];
   end

   always_comb begin
      status.search_needed = need_curve && !end_hi && !end_lo;
      status.seg_found     = found;
      status.div_done      = (dcnt_ff == DCNT_LAST);
      status.min_busy      = mbusy_ff;
      status.rsp_free      = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      thr_in          = thr_ff;
      ext_cert_in     = ext_cert_ff;
      cell_max_in     = cell_max_ff;
      tpp_in          = tpp_ff;
      settle_ticks_in = settle_ticks_ff;
      tpm_in          = tpm_ff;
      primed_in       = primed_ff;
      ext_mode_in     = ext_mode_ff;
      last_pct_in     = last_pct_ff;
      ext_ticks_in    = ext_ticks_ff;
      settle_in       = settle_ff;
      ptr_in          = ptr_ff;
      push_in         = push_ff;
      fill_in         = fill_ff;
      prime_val_in    = prime_val_ff;
      mv_in           = mv_ff;
      cv_in           = cv_ff;
      idx_in          = idx_ff;
      rem_in          = rem_ff;
      qlow_in         = qlow_ff;
      den_in          = den_ff;
      base_in         = base_ff;
      zspan_in        = zspan_ff;
      dcnt_in         = dcnt_ff;
      mdvd_in         = mdvd_ff;
      mrem_in         = mrem_ff;
      mdiv_in         = mdiv_ff;
      mcnt_in         = mcnt_ff;
      mbusy_in        = mbusy_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_in          = rsp_ff;

      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_STEP_THRESHOLD:   thr_in          = csr_wdata[MV_W-1:0];
            CSR_EXTERNAL_CERTAIN: ext_cert_in     = csr_wdata[MV_W-1:0];
            CSR_CELL_MAX:         cell_max_in     = csr_wdata[MV_W-1:0];
            CSR_TICKS_PER_PUSH:   tpp_in          = csr_wdata[CNT8_W-1:0];
            CSR_SETTLE_TICKS:     settle_ticks_in = csr_wdata[CNT8_W-1:0];
            CSR_TICKS_PER_MINUTE: tpm_in          = csr_wdata[TPM_W-1:0];
            default: ;
         endcase
      end

      if (cmd.load) begin
         mv_in = req_sample_mv;
      end

      if (cmd.decide) begin
         primed_in = 1'b1;
         if (!primed_ff) begin
            prime_val_in = mv_ff;
         end
         ext_mode_in  = mode_new;
         ext_ticks_in = ticks_new;
         if (!mode_new && (settle_mid != '0)) begin
            settle_in = settle_mid - CNT8_W'(1);
         end else begin
            settle_in = settle_mid;
         end
         if (need_curve) begin
            if (end_hi) begin
               last_pct_in = signed'(PCT_W'(CURVE_PC[0]));
            end else if (end_lo) begin
               last_pct_in = signed'(PCT_W'(CURVE_PC[CURVE_POINTS-1]));
            end
         end
         cv_in  = target;
         idx_in = CURVE_IDX_W'(1);
         if (push_now) begin
            push_in = '0;
            ptr_in  = (ptr_ff == PTR_LAST) ? '0 : ptr_ff + PTR_W'(1);
            fill_in = (fill_ff == FILL_FULL) ? fill_ff : fill_ff + FILL_W'(1);
         end else begin
            push_in = push_next;
         end
         mdvd_in  = ticks_new;
         mrem_in  = '0;
         mdiv_in  = (tpm_ff == '0) ? TPM_W'(1) : tpm_ff;
         mcnt_in  = '0;
         mbusy_in = 1'b1;
      end else if (mbusy_ff) begin
         mrem_in = mq ? mdiff[TPM_W-1:0] : mshift[TPM_W-1:0];
         mdvd_in = {mdvd_ff[TICK_W-2:0], mq};
         mcnt_in = mcnt_ff + MCNT_W'(1);
         if (mcnt_ff == MCNT_LAST) begin
            mbusy_in = 1'b0;
         end
      end

      if (cmd.search) begin
         if (found) begin
            rem_in   = num[NUM_W-1:PCT_QW];
            qlow_in  = num[PCT_QW-1:0];
            den_in   = span_mv;
            base_in  = CURVE_PC[idx_ff];
            zspan_in = (span_mv == '0);
            dcnt_in  = '0;
         end else begin
            idx_in = idx_ff + CURVE_IDX_W'(1);
         end
      end

      if (cmd.divide) begin
         rem_in  = qbit ? ddiff[MV_W-1:0] : dshift[MV_W-1:0];
         qlow_in = quot;
         dcnt_in = dcnt_ff + DCNT_W'(1);
         if (dcnt_ff == DCNT_LAST) begin
            if (zspan_ff) begin
               last_pct_in = signed'(PCT_W'(base_ff));
            end else begin
               last_pct_in = signed'(PCT_W'(base_ff) + PCT_W'(quot));
            end
         end
      end

      if (cmd.emit) begin
         rsp_valid_in            = 1'b1;
         rsp_in.on_external      = ext_mode_ff;
         rsp_in.charge_percent   = last_pct_ff;
         rsp_in.minutes_external = minutes_sat;
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff          <= STEP_THRESHOLD_RST;
         ext_cert_ff     <= EXTERNAL_CERTAIN_RST;
         cell_max_ff     <= CELL_MAX_RST;
         tpp_ff          <= TICKS_PER_PUSH_RST;
         settle_ticks_ff <= SETTLE_TICKS_RST;
         tpm_ff          <= TICKS_PER_MINUTE_RST;
         primed_ff       <= 1'b0;
         ext_mode_ff     <= 1'b0;
         last_pct_ff     <= PCT_UNKNOWN;
         ext_ticks_ff    <= '0;
         settle_ff       <= '0;
         ptr_ff          <= '0;
         push_ff         <= '0;
         fill_ff         <= '0;
         mbusy_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         thr_ff          <= thr_in;
         ext_cert_ff     <= ext_cert_in;
         cell_max_ff     <= cell_max_in;
         tpp_ff          <= tpp_in;
         settle_ticks_ff <= settle_ticks_in;
         tpm_ff          <= tpm_in;
         primed_ff       <= primed_in;
         ext_mode_ff     <= ext_mode_in;
         last_pct_ff     <= last_pct_in;
         ext_ticks_ff    <= ext_ticks_in;
         settle_ff       <= settle_in;
         ptr_ff          <= ptr_in;
         push_ff         <= push_in;
         fill_ff         <= fill_in;
         mbusy_ff        <= mbusy_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prime_val_ff <= prime_val_in;
      mv_ff        <= mv_in;
      cv_ff        <= cv_in;
      idx_ff       <= idx_in;
      rem_ff       <= rem_in;
      qlow_ff      <= qlow_in;
      den_ff       <= den_in;
      base_ff      <= base_in;
      zspan_ff     <= zspan_in;
      dcnt_ff      <= dcnt_in;
      mdvd_ff      <= mdvd_in;
      mrem_ff      <= mrem_in;
      mdiv_ff      <= mdiv_in;
      mcnt_ff      <= mcnt_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_min_start: assert property (@(posedge clock) disable iff (reset)
      cmd.decide |=> mbusy_ff)
      else $error("minutes divider not started after decision");

   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      (last_pct_ff >= PCT_UNKNOWN) && (last_pct_ff <= 8'sd100))
      else $error("charge percent out of range");

   a_batt_ticks: assert property (@(posedge clock) disable iff (reset)
      !ext_mode_ff |-> (ext_ticks_ff == '0))
      else $error("external tick count nonzero on battery");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_FULL)
      else $error("history fill count beyond ring depth");

endmodule

`default_nettype wire

// ===== design/battery_gauge_power_detect.sv =====
// ----------------------------------------------------------------------------
// battery_gauge_power_detect
// Rail-voltage supply detector and battery percent gauge.
//
// req_if carries one filtered rail sample in millivolts per tick; rsp_if
// returns one result per request: supply mode, last known charge percent
// (-1 when unknown) and whole minutes spent on external power.
// csr_wr_en/csr_index/csr_wdata write the six threshold and timing
// registers; write them only while no request is in flight.
// The result waits for the 32-step bit-serial minutes divider; the curve
// segment search and percent divide run alongside it.
// One request is processed at a time. A finished result sits in the output
// register; when the receiver stalls, the next request is still accepted
// and processed, and waits at the end until the output register frees.
// Reset restores the register defaults, clears the gauge state and marks
// the history ring empty; the first sample after reset primes the ring.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_gauge_power_detect import bgpd_pkg::*; #(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   bgpd_stream_if.sink            req_if,
   bgpd_stream_if.source          rsp_if,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cmd_type    cmd;
   status_type status;

   bgpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bgpd_dp #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_sample_mv (req_if.payload.sample_mv),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_valid     (rsp_if.valid),
      .rsp_ready     (rsp_if.ready),
      .rsp_payload   (rsp_if.payload)
   );

endmodule

`default_nettype wire
